[sv/isa_pkg.sv]
// ----------------------------------------------------------------------------
// Integer stack ALU package
// Shared constants, codes and state types of the integer evaluation stack.
// ----------------------------------------------------------------------------
package isa_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CNT_W       = $clog2(DATA_W);
  localparam int unsigned ADD_W       = DATA_W + 2;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned OP_W        = 5;
  localparam int unsigned DEPTH_OUT_W = 7;
  localparam int unsigned FAULT_W     = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_DUP    = 3'd2,
    KIND_UNARY  = 3'd3,
    KIND_BINARY = 3'd4
  } kind_e;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_UNDER = 2'd1,
    FAULT_OVER  = 2'd2
  } fault_e;

  localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 5'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 5'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 5'd3;
  localparam logic [OP_W-1:0] OP_MOD  = 5'd4;
  localparam logic [OP_W-1:0] OP_EQ   = 5'd5;
  localparam logic [OP_W-1:0] OP_NE   = 5'd6;
  localparam logic [OP_W-1:0] OP_GT   = 5'd7;
  localparam logic [OP_W-1:0] OP_GE   = 5'd8;
  localparam logic [OP_W-1:0] OP_LT   = 5'd9;
  localparam logic [OP_W-1:0] OP_LE   = 5'd10;
  localparam logic [OP_W-1:0] OP_LAND = 5'd11;
  localparam logic [OP_W-1:0] OP_LOR  = 5'd12;
  localparam logic [OP_W-1:0] OP_AND  = 5'd13;
  localparam logic [OP_W-1:0] OP_OR   = 5'd14;
  localparam logic [OP_W-1:0] OP_XOR  = 5'd15;
  localparam logic [OP_W-1:0] OP_SHL  = 5'd16;
  localparam logic [OP_W-1:0] OP_SAR  = 5'd17;
  localparam logic [OP_W-1:0] OP_SHR  = 5'd18;

  localparam logic [OP_W-1:0] UOP_PLUS = 5'd0;
  localparam logic [OP_W-1:0] UOP_NEG  = 5'd1;
  localparam logic [OP_W-1:0] UOP_NOT  = 5'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_OPND,
    ST_EXEC,
    ST_ABS_L,
    ST_ABS_R,
    ST_DIV,
    ST_FIX,
    ST_WRITE,
    ST_RD_TOP,
    ST_TOP_LD,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    ADD_SUM,
    ADD_DIFF,
    ADD_NEG_L,
    ADD_NEG_R,
    ADD_DIV,
    ADD_NEG_RES
  } add_sel_e;

endpackage

[sv/isa_if.sv]
// ----------------------------------------------------------------------------
// Integer stack ALU channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface isa_in_if;
  logic                                valid;
  logic                                ready;
  logic        [isa_pkg::KIND_W-1:0]   kind;
  logic signed [isa_pkg::DATA_W-1:0]   push_value;
  logic        [isa_pkg::OP_W-1:0]     op_code;

  modport source (output valid, kind, push_value, op_code, input ready);
  modport sink   (input valid, kind, push_value, op_code, output ready);
endinterface

interface isa_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [isa_pkg::DATA_W-1:0]     top_value;
  logic        [isa_pkg::DEPTH_OUT_W-1:0] stack_depth;
  logic                                  div_by_zero;
  logic        [isa_pkg::FAULT_W-1:0]    stack_fault;

  modport source (output valid, top_value, stack_depth, div_by_zero, stack_fault,
                  input ready);
  modport sink   (input valid, top_value, stack_depth, div_by_zero, stack_fault,
                  output ready);
endinterface

[sv/integer_stack_alu.sv]
// ----------------------------------------------------------------------------
// Integer stack ALU
// Evaluation stack with push, pop, duplicate and unary/binary integer ops.
//
// Usage:
//   in_i carries one command item (kind, push_value, op_code); out_o returns
//   one result item per command: new top (0 when empty), depth, zero-divisor
//   flag and stack fault code. Both channels use valid/ready.
//   A command is taken only while the sequencer is idle. Push, duplicate,
//   unknown kinds and pops that leave nothing to fetch go from decode to
//   output; a pop that fetches a new top first reads the stack RAM (after
//   the operand state for an unknown binary op); unary ops pass execute and
//   write, binary ops an operand state too; div and mod by a nonzero divisor
//   add two absolute-value states, the 32 restoring steps of the divider and
//   a sign fix, all on the single 34-bit adder; the stack RAM has one read port.
//   The result sits in an output register: the next command is accepted
//   while it waits, and a stalled receiver holds the block only when the
//   following result is ready to be loaded.
//   Reset empties the stack and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
module integer_stack_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  isa_in_if.sink            in_i,
  isa_out_if.source         out_o
);

  isa_pkg::state_e   state_q, state_d;
  isa_pkg::add_sel_e add_sel;

  logic [isa_pkg::KIND_W-1:0]  kind_q;
  logic [isa_pkg::DATA_W-1:0]  pv_q;
  logic [isa_pkg::OP_W-1:0]    op_q;
  logic [isa_pkg::SP_W-1:0]    sp_q;
  logic [isa_pkg::DATA_W-1:0]  top_q;
  logic [isa_pkg::DATA_W-1:0]  l_q;
  logic [isa_pkg::DATA_W-1:0]  r_q;
  logic [isa_pkg::DATA_W-1:0]  res_q;
  logic [isa_pkg::DATA_W-1:0]  rem_q;
  logic [isa_pkg::DATA_W-1:0]  quo_q;
  logic [isa_pkg::DATA_W-1:0]  dmag_q;
  logic [isa_pkg::CNT_W-1:0]   cnt_q;
  logic                        two_q;
  logic                        dz_q;
  logic [isa_pkg::FAULT_W-1:0] fault_q;
  logic [isa_pkg::DATA_W-1:0]  rdata_q;

  logic                        out_valid_q;
  logic [isa_pkg::DATA_W-1:0]  out_top_q;
  logic [isa_pkg::SP_W-1:0]    out_sp_q;
  logic                        out_dz_q;
  logic [isa_pkg::FAULT_W-1:0] out_fault_q;

  logic [isa_pkg::DATA_W-1:0]  mem [isa_pkg::STACK_DEPTH];

  logic                        mem_we;
  logic [isa_pkg::SP_W-1:0]    mem_waddr;
  logic [isa_pkg::DATA_W-1:0]  mem_wdata;
  logic [isa_pkg::SP_W-1:0]    mem_raddr;

  logic                        sp_empty, sp_full, sp_two;
  logic                        op_known_bin, op_known_un, op_divmod;
  logic                        in_acc, out_load;

  logic [isa_pkg::ADD_W-1:0]   add_a, add_b, add_sum;
  logic                        add_cin;
  logic [isa_pkg::DATA_W-1:0]  fix_val;
  logic                        fix_neg;
  logic [isa_pkg::DATA_W:0]    div_shift;
  logic [isa_pkg::DATA_W-1:0]  mul_lo;
  logic [isa_pkg::DATA_W-1:0]  sar_res;
  logic [4:0]                  sh;
  logic                        lt, eq;
  logic [isa_pkg::DATA_W-1:0]  res_d;

  assign sp_empty     = (sp_q == '0);
  assign sp_full      = (sp_q == isa_pkg::SP_W'(isa_pkg::STACK_DEPTH));
  assign sp_two       = (sp_q >= isa_pkg::SP_W'(2));
  assign op_known_bin = (op_q <= isa_pkg::OP_SHR);
  assign op_known_un  = (op_q <= isa_pkg::UOP_NOT);
  assign op_divmod    = (op_q == isa_pkg::OP_DIV) || (op_q == isa_pkg::OP_MOD);
  assign in_acc       = in_i.valid && in_i.ready;
  assign out_load     = (state_q == isa_pkg::ST_OUT) && (!out_valid_q || out_o.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      isa_pkg::ST_IDLE: begin
        if (in_i.valid) state_d = isa_pkg::ST_DECODE;
      end
      isa_pkg::ST_DECODE: begin
        case (kind_q)
          isa_pkg::KIND_POP:    state_d = sp_two ? isa_pkg::ST_RD_TOP : isa_pkg::ST_OUT;
          isa_pkg::KIND_UNARY: begin
            if (op_known_un) state_d = isa_pkg::ST_EXEC;
            else state_d = sp_two ? isa_pkg::ST_RD_TOP : isa_pkg::ST_OUT;
          end
          isa_pkg::KIND_BINARY: state_d = isa_pkg::ST_OPND;
          default:              state_d = isa_pkg::ST_OUT;
        endcase
      end
      isa_pkg::ST_OPND: begin
        if (op_known_bin) state_d = isa_pkg::ST_EXEC;
        else state_d = sp_empty ? isa_pkg::ST_OUT : isa_pkg::ST_RD_TOP;
      end
      isa_pkg::ST_EXEC: begin
        if (kind_q == isa_pkg::KIND_BINARY && op_divmod && r_q != '0) begin
          state_d = isa_pkg::ST_ABS_L;
        end else begin
          state_d = isa_pkg::ST_WRITE;
        end
      end
      isa_pkg::ST_ABS_L:  state_d = isa_pkg::ST_ABS_R;
      isa_pkg::ST_ABS_R:  state_d = isa_pkg::ST_DIV;
      isa_pkg::ST_DIV: begin
        if (cnt_q == isa_pkg::CNT_W'(isa_pkg::DATA_W - 1)) state_d = isa_pkg::ST_FIX;
      end
      isa_pkg::ST_FIX:    state_d = isa_pkg::ST_WRITE;
      isa_pkg::ST_WRITE:  state_d = isa_pkg::ST_OUT;
      isa_pkg::ST_RD_TOP: state_d = isa_pkg::ST_TOP_LD;
      isa_pkg::ST_TOP_LD: state_d = isa_pkg::ST_OUT;
      isa_pkg::ST_OUT: begin
        if (!out_valid_q || out_o.ready) state_d = isa_pkg::ST_IDLE;
      end
      default:            state_d = isa_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_i.ready = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = sp_q;
    mem_wdata  = pv_q;
    mem_raddr  = sp_q - isa_pkg::SP_W'(1);
    add_sel    = isa_pkg::ADD_DIFF;
    case (state_q)
      isa_pkg::ST_IDLE: in_i.ready = 1'b1;
      isa_pkg::ST_DECODE: begin
        mem_raddr = sp_q - isa_pkg::SP_W'(2);
        if (kind_q == isa_pkg::KIND_PUSH && !sp_full) begin
          mem_we = 1'b1;
        end else if (kind_q == isa_pkg::KIND_DUP && !sp_full) begin
          mem_we    = 1'b1;
          mem_wdata = sp_empty ? '0 : top_q;
        end
      end
      isa_pkg::ST_EXEC: begin
        if (kind_q == isa_pkg::KIND_UNARY) add_sel = isa_pkg::ADD_NEG_R;
        else if (op_q == isa_pkg::OP_ADD) add_sel = isa_pkg::ADD_SUM;
        else add_sel = isa_pkg::ADD_DIFF;
      end
      isa_pkg::ST_ABS_L: add_sel = isa_pkg::ADD_NEG_L;
      isa_pkg::ST_ABS_R: add_sel = isa_pkg::ADD_NEG_R;
      isa_pkg::ST_DIV:   add_sel = isa_pkg::ADD_DIV;
      isa_pkg::ST_FIX:   add_sel = isa_pkg::ADD_NEG_RES;
      isa_pkg::ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = res_q;
      end
      default: ;
    endcase
  end

  // Shared adder
  assign fix_val   = (op_q == isa_pkg::OP_DIV) ? quo_q : rem_q;
  assign fix_neg   = (op_q == isa_pkg::OP_DIV) ? (l_q[isa_pkg::DATA_W-1] ^ r_q[isa_pkg::DATA_W-1])
                                               : l_q[isa_pkg::DATA_W-1];
  assign div_shift = {rem_q, quo_q[isa_pkg::DATA_W-1]};

  always_comb begin
    add_a   = {{2{l_q[isa_pkg::DATA_W-1]}}, l_q};
    add_b   = ~{{2{r_q[isa_pkg::DATA_W-1]}}, r_q};
    add_cin = 1'b1;
    case (add_sel)
      isa_pkg::ADD_SUM: begin
        add_b   = {{2{r_q[isa_pkg::DATA_W-1]}}, r_q};
        add_cin = 1'b0;
      end
      isa_pkg::ADD_DIFF: ;
      isa_pkg::ADD_NEG_L: begin
        add_a = '0;
        add_b = ~{{2{l_q[isa_pkg::DATA_W-1]}}, l_q};
      end
      isa_pkg::ADD_NEG_R: add_a = '0;
      isa_pkg::ADD_DIV: begin
        add_a = {1'b0, div_shift};
        add_b = ~{2'b00, dmag_q};
      end
      isa_pkg::ADD_NEG_RES: begin
        add_a = '0;
        add_b = ~{{2{fix_val[isa_pkg::DATA_W-1]}}, fix_val};
      end
      default: ;
    endcase
  end

  assign add_sum = add_a + add_b + isa_pkg::ADD_W'(add_cin);

  // Result select
  assign sh      = r_q[4:0];
  assign mul_lo  = l_q * r_q;
  assign sar_res = isa_pkg::DATA_W'($signed(l_q) >>> sh);
  assign lt      = add_sum[isa_pkg::ADD_W-1];
  assign eq      = (add_sum[isa_pkg::DATA_W-1:0] == '0);

  always_comb begin
    res_d = '0;
    if (kind_q == isa_pkg::KIND_UNARY) begin
      case (op_q)
        isa_pkg::UOP_PLUS: res_d = r_q;
        isa_pkg::UOP_NEG:  res_d = add_sum[isa_pkg::DATA_W-1:0];
        isa_pkg::UOP_NOT:  res_d = ~r_q;
        default:           res_d = '0;
      endcase
    end else begin
      case (op_q)
        isa_pkg::OP_ADD,
        isa_pkg::OP_SUB:  res_d = add_sum[isa_pkg::DATA_W-1:0];
        isa_pkg::OP_MUL:  res_d = mul_lo;
        isa_pkg::OP_EQ:   res_d = isa_pkg::DATA_W'(eq);
        isa_pkg::OP_NE:   res_d = isa_pkg::DATA_W'(!eq);
        isa_pkg::OP_GT:   res_d = isa_pkg::DATA_W'(!lt && !eq);
        isa_pkg::OP_GE:   res_d = isa_pkg::DATA_W'(!lt);
        isa_pkg::OP_LT:   res_d = isa_pkg::DATA_W'(lt);
        isa_pkg::OP_LE:   res_d = isa_pkg::DATA_W'(lt || eq);
        isa_pkg::OP_LAND: res_d = isa_pkg::DATA_W'((l_q != '0) && (r_q != '0));
        isa_pkg::OP_LOR:  res_d = isa_pkg::DATA_W'((l_q != '0) || (r_q != '0));
        isa_pkg::OP_AND:  res_d = l_q & r_q;
        isa_pkg::OP_OR:   res_d = l_q | r_q;
        isa_pkg::OP_XOR:  res_d = l_q ^ r_q;
        isa_pkg::OP_SHL:  res_d = l_q << sh;
        isa_pkg::OP_SAR:  res_d = sar_res;
        isa_pkg::OP_SHR:  res_d = l_q >> sh;
        default:          res_d = '0;
      endcase
    end
  end

  // Stack RAM
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr[isa_pkg::IDX_W-1:0]] <= mem_wdata;
    rdata_q <= mem[mem_raddr[isa_pkg::IDX_W-1:0]];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isa_pkg::ST_IDLE;
      sp_q        <= '0;
      fault_q     <= isa_pkg::FAULT_NONE;
      dz_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        isa_pkg::ST_IDLE: begin
          if (in_acc) begin
            fault_q <= isa_pkg::FAULT_NONE;
            dz_q    <= 1'b0;
          end
        end
        isa_pkg::ST_DECODE: begin
          case (kind_q)
            isa_pkg::KIND_PUSH: begin
              if (sp_full) fault_q <= isa_pkg::FAULT_OVER;
              else sp_q <= sp_q + isa_pkg::SP_W'(1);
            end
            isa_pkg::KIND_POP: begin
              if (sp_empty) fault_q <= isa_pkg::FAULT_UNDER;
              else sp_q <= sp_q - isa_pkg::SP_W'(1);
            end
            isa_pkg::KIND_DUP: begin
              if (sp_empty) begin
                fault_q <= isa_pkg::FAULT_UNDER;
                sp_q    <= isa_pkg::SP_W'(1);
              end else if (sp_full) begin
                fault_q <= isa_pkg::FAULT_OVER;
              end else begin
                sp_q <= sp_q + isa_pkg::SP_W'(1);
              end
            end
            isa_pkg::KIND_UNARY: begin
              if (sp_empty) fault_q <= isa_pkg::FAULT_UNDER;
              else sp_q <= sp_q - isa_pkg::SP_W'(1);
            end
            isa_pkg::KIND_BINARY: begin
              if (!sp_two) begin
                fault_q <= isa_pkg::FAULT_UNDER;
                sp_q    <= '0;
              end else begin
                sp_q <= sp_q - isa_pkg::SP_W'(2);
              end
            end
            default: ;
          endcase
        end
        isa_pkg::ST_EXEC: begin
          if (kind_q == isa_pkg::KIND_BINARY && op_divmod && r_q == '0) dz_q <= 1'b1;
        end
        isa_pkg::ST_WRITE: sp_q <= sp_q + isa_pkg::SP_W'(1);
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_top_q   <= sp_empty ? '0 : top_q;
      out_sp_q    <= sp_q;
      out_dz_q    <= dz_q;
      out_fault_q <= fault_q;
    end
    case (state_q)
      isa_pkg::ST_IDLE: begin
        if (in_acc) begin
          kind_q <= in_i.kind;
          pv_q   <= in_i.push_value;
          op_q   <= in_i.op_code;
        end
      end
      isa_pkg::ST_DECODE: begin
        r_q   <= sp_empty ? '0 : top_q;
        two_q <= sp_two;
        if (kind_q == isa_pkg::KIND_PUSH && !sp_full) top_q <= pv_q;
        if (kind_q == isa_pkg::KIND_DUP && sp_empty) top_q <= '0;
      end
      isa_pkg::ST_OPND: l_q <= two_q ? rdata_q : '0;
      isa_pkg::ST_EXEC: begin
        res_q <= res_d;
        if (kind_q == isa_pkg::KIND_UNARY) l_q <= '0;
      end
      isa_pkg::ST_ABS_L: begin
        quo_q <= l_q[isa_pkg::DATA_W-1] ? add_sum[isa_pkg::DATA_W-1:0] : l_q;
        rem_q <= '0;
        cnt_q <= '0;
      end
      isa_pkg::ST_ABS_R: begin
        dmag_q <= r_q[isa_pkg::DATA_W-1] ? add_sum[isa_pkg::DATA_W-1:0] : r_q;
      end
      isa_pkg::ST_DIV: begin
        if (!add_sum[isa_pkg::ADD_W-1]) rem_q <= add_sum[isa_pkg::DATA_W-1:0];
        else rem_q <= div_shift[isa_pkg::DATA_W-1:0];
        quo_q <= {quo_q[isa_pkg::DATA_W-2:0], !add_sum[isa_pkg::ADD_W-1]};
        cnt_q <= cnt_q + isa_pkg::CNT_W'(1);
      end
      isa_pkg::ST_FIX:    res_q <= fix_neg ? add_sum[isa_pkg::DATA_W-1:0] : fix_val;
      isa_pkg::ST_WRITE:  top_q <= res_q;
      isa_pkg::ST_TOP_LD: top_q <= rdata_q;
      default: ;
    endcase
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.top_value   = out_top_q;
  assign out_o.stack_depth = isa_pkg::DEPTH_OUT_W'(out_sp_q);
  assign out_o.div_by_zero = out_dz_q;
  assign out_o.stack_fault = out_fault_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= isa_pkg::SP_W'(isa_pkg::STACK_DEPTH))
    else $error("stack pointer beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_dz_q |-> out_sp_q != '0 && out_fault_q != isa_pkg::FAULT_OVER)
    else $error("zero divisor flagged without a pushed result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_fault_q == isa_pkg::FAULT_OVER
      |-> out_sp_q == isa_pkg::SP_W'(isa_pkg::STACK_DEPTH))
    else $error("overflow flagged on a stack that is not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == isa_pkg::ST_DIV && $past(state_q) == isa_pkg::ST_DIV
      |-> cnt_q == $past(cnt_q) + isa_pkg::CNT_W'(1))
    else $error("divider step count skipped");

endmodule

[bench/integer_stack_alu_test.sv]
// ----------------------------------------------------------------------------
// Integer stack ALU testbench
// Drives command items with random gaps and stalls the result channel at
// random. A software copy of the stack predicts every result item, which is
// compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module integer_stack_alu_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT   = 400000;
  localparam int unsigned RANDOM_CMDS = 1600;
  localparam int unsigned SHOWN_ERRS  = 10;

  typedef struct packed {
    logic [isa_pkg::DATA_W-1:0]      top;
    logic [isa_pkg::DEPTH_OUT_W-1:0] depth;
    logic                            dz;
    logic [isa_pkg::FAULT_W-1:0]     fault;
  } result_t;

  logic clk_i;
  logic rst_ni;

  isa_in_if  in_ch ();
  isa_out_if out_ch ();

  integer_stack_alu dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  logic [isa_pkg::DATA_W-1:0]  stack_words [isa_pkg::STACK_DEPTH];
  int unsigned                 held;
  logic [isa_pkg::FAULT_W-1:0] fault_now;
  result_t                     due_results [$];
  int unsigned                 mismatches = 0;
  int unsigned                 cycles = 0;
  bit                          no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int idle_draw();
    return no_gaps ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [isa_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      4, 5: return 32'($urandom_range(0, 16) - 8);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [isa_pkg::DATA_W-1:0] take_top();
    if (held == 0) begin
      fault_now = isa_pkg::FAULT_UNDER;
      return '0;
    end
    held--;
    return stack_words[held];
  endfunction

  function automatic void put_top(input logic [isa_pkg::DATA_W-1:0] v);
    if (held >= isa_pkg::STACK_DEPTH) begin
      fault_now = isa_pkg::FAULT_OVER;
      return;
    end
    stack_words[held] = v;
    held++;
  endfunction

  function automatic result_t eval_stack_cmd(input logic [isa_pkg::KIND_W-1:0] kind,
                                             input logic [isa_pkg::DATA_W-1:0] value,
                                             input logic [isa_pkg::OP_W-1:0]   op);
    logic [isa_pkg::DATA_W-1:0]        l;
    logic [isa_pkg::DATA_W-1:0]        r;
    logic [isa_pkg::DATA_W-1:0]        res;
    logic signed [isa_pkg::DATA_W-1:0] sl;
    logic signed [isa_pkg::DATA_W-1:0] sr;
    longint                            q;
    logic                              dz;
    logic                              has;
    result_t                           item;
    fault_now = isa_pkg::FAULT_NONE;
    dz        = 1'b0;
    has       = 1'b1;
    res       = '0;
    case (kind)
      isa_pkg::KIND_PUSH: put_top(value);
      isa_pkg::KIND_POP: void'(take_top());
      isa_pkg::KIND_DUP: begin
        if (held == 0) begin
          fault_now = isa_pkg::FAULT_UNDER;
          put_top('0);
        end else begin
          put_top(stack_words[held-1]);
        end
      end
      isa_pkg::KIND_UNARY: begin
        r = take_top();
        case (op)
          isa_pkg::UOP_PLUS: put_top(r);
          isa_pkg::UOP_NEG:  put_top(-r);
          isa_pkg::UOP_NOT:  put_top(~r);
          default: ;
        endcase
      end
      isa_pkg::KIND_BINARY: begin
        r  = take_top();
        l  = take_top();
        sl = l;
        sr = r;
        case (op)
          isa_pkg::OP_ADD: res = l + r;
          isa_pkg::OP_SUB: res = l - r;
          isa_pkg::OP_MUL: res = l * r;
          isa_pkg::OP_DIV, isa_pkg::OP_MOD: begin
            if (r == '0) begin
              dz = 1'b1;
            end else begin
              q   = (op == isa_pkg::OP_DIV) ? longint'(sl) / longint'(sr)
                                            : longint'(sl) % longint'(sr);
              res = q[isa_pkg::DATA_W-1:0];
            end
          end
          isa_pkg::OP_EQ:   res = {31'b0, sl == sr};
          isa_pkg::OP_NE:   res = {31'b0, sl != sr};
          isa_pkg::OP_GT:   res = {31'b0, sl > sr};
          isa_pkg::OP_GE:   res = {31'b0, sl >= sr};
          isa_pkg::OP_LT:   res = {31'b0, sl < sr};
          isa_pkg::OP_LE:   res = {31'b0, sl <= sr};
          isa_pkg::OP_LAND: res = {31'b0, (l != '0) && (r != '0)};
          isa_pkg::OP_LOR:  res = {31'b0, (l != '0) || (r != '0)};
          isa_pkg::OP_AND:  res = l & r;
          isa_pkg::OP_OR:   res = l | r;
          isa_pkg::OP_XOR:  res = l ^ r;
          isa_pkg::OP_SHL:  res = l << r[4:0];
          isa_pkg::OP_SAR:  res = sl >>> r[4:0];
          isa_pkg::OP_SHR:  res = l >> r[4:0];
          default: has = 1'b0;
        endcase
        if (has) put_top(res);
      end
      default: ;
    endcase
    item.top   = (held > 0) ? stack_words[held-1] : '0;
    item.depth = isa_pkg::DEPTH_OUT_W'(held);
    item.dz    = dz;
    item.fault = fault_now;
    return item;
  endfunction

  task automatic send_cmd(input logic [isa_pkg::KIND_W-1:0] kind,
                          input logic [isa_pkg::DATA_W-1:0] value,
                          input logic [isa_pkg::OP_W-1:0] op);
    int gap;
    gap = idle_draw();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.push_value <= value;
    in_ch.op_code    <= op;
    do @(posedge clk_i); while (!in_ch.ready);
    due_results.insert(due_results.size(), eval_stack_cmd(kind, value, op));
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
  endtask

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN_ERRS)
        $display("unexpected result: top %h depth %0d dz %0b fault %0d",
                 out_ch.top_value, out_ch.stack_depth, out_ch.div_by_zero,
                 out_ch.stack_fault);
    end else begin
      want = due_results.pop_front();
      if (out_ch.top_value !== want.top || out_ch.stack_depth !== want.depth ||
          out_ch.div_by_zero !== want.dz || out_ch.stack_fault !== want.fault) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRS)
          $display("mismatch: expected top %h depth %0d dz %0b fault %0d,",
                   want.top, want.depth, want.dz, want.fault,
                   " got top %h depth %0d dz %0b fault %0d",
                   out_ch.top_value, out_ch.stack_depth, out_ch.div_by_zero,
                   out_ch.stack_fault);
      end
    end
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idle_draw();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      check_result();
    end
  end

  task automatic test_push_pop();
    send_cmd(isa_pkg::KIND_POP, '0, isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_DUP, '0, isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_PUSH, 32'h0000_0005, isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_BINARY, '0, isa_pkg::OP_SUB);
    send_cmd(isa_pkg::KIND_POP, '0, isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_POP, '0, isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_BINARY, '0, isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_PUSH, 32'h7fff_ffff, isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_PUSH, 32'h8000_0000, isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_PUSH, '1, isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_DUP, '0, isa_pkg::OP_ADD);
    repeat (5) send_cmd(isa_pkg::KIND_POP, '0, isa_pkg::OP_ADD);
  endtask

  task automatic test_unary_ops();
    send_cmd(isa_pkg::KIND_UNARY, '0, isa_pkg::UOP_NEG);
    send_cmd(isa_pkg::KIND_PUSH, 32'h8000_0000, isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_UNARY, '0, isa_pkg::UOP_NEG);
    send_cmd(isa_pkg::KIND_UNARY, '0, isa_pkg::UOP_NOT);
    send_cmd(isa_pkg::KIND_UNARY, '0, isa_pkg::UOP_PLUS);
    send_cmd(isa_pkg::KIND_UNARY, '0,
             isa_pkg::OP_W'($urandom_range(int'(isa_pkg::UOP_NOT) + 1,
                                           (1 << isa_pkg::OP_W) - 1)));
  endtask

  task automatic test_binary_ops();
    send_cmd(isa_pkg::KIND_PUSH, pick_word(), isa_pkg::OP_ADD);
    for (int op = int'(isa_pkg::OP_ADD); op <= int'(isa_pkg::OP_SHR); op++) begin
      send_cmd(isa_pkg::KIND_PUSH, pick_word(), isa_pkg::OP_ADD);
      send_cmd(isa_pkg::KIND_BINARY, '0, isa_pkg::OP_W'(op));
    end
    send_cmd(isa_pkg::KIND_PUSH, pick_word(), isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_BINARY, '0,
             isa_pkg::OP_W'($urandom_range(int'(isa_pkg::OP_SHR) + 1,
                                           (1 << isa_pkg::OP_W) - 1)));
    send_cmd(isa_pkg::KIND_W'($urandom_range(int'(isa_pkg::KIND_BINARY) + 1,
                                             (1 << isa_pkg::KIND_W) - 1)),
             $urandom(), isa_pkg::OP_W'($urandom()));
  endtask

  task automatic test_division_cases();
    logic [isa_pkg::DATA_W-1:0] lhs [9];
    logic [isa_pkg::DATA_W-1:0] rhs [9];
    logic [isa_pkg::OP_W-1:0]   ops [9];
    lhs = '{32'h0000_0009, 32'hffff_fff7, 32'h8000_0000, 32'h8000_0000, 32'hffff_fff9,
            32'hffff_fff9, 32'h0000_0007, 32'h0000_0001, 32'hffff_fff0};
    rhs = '{'0, '0, '1, '1, 32'h0000_0002, 32'h0000_0002, 32'hffff_fffe, 32'h0000_0021,
            32'hffff_ffe2};
    ops = '{isa_pkg::OP_DIV, isa_pkg::OP_MOD, isa_pkg::OP_DIV, isa_pkg::OP_MOD,
            isa_pkg::OP_DIV, isa_pkg::OP_MOD, isa_pkg::OP_MOD, isa_pkg::OP_SHL,
            isa_pkg::OP_SAR};
    for (int i = 0; i < 9; i++) begin
      send_cmd(isa_pkg::KIND_PUSH, lhs[i], isa_pkg::OP_ADD);
      send_cmd(isa_pkg::KIND_PUSH, rhs[i], isa_pkg::OP_ADD);
      send_cmd(isa_pkg::KIND_BINARY, '0, ops[i]);
    end
    send_cmd(isa_pkg::KIND_PUSH, 32'hffff_fff0, isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_PUSH, 32'hffff_ffe2, isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_BINARY, '0, isa_pkg::OP_SHR);
  endtask

  task automatic test_overflow();
    wait_drain();
    no_gaps = 1'b1;
    while (held < isa_pkg::STACK_DEPTH) send_cmd(isa_pkg::KIND_PUSH, pick_word(), isa_pkg::OP_ADD);
    no_gaps = 1'b0;
    send_cmd(isa_pkg::KIND_PUSH, pick_word(), isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_DUP, '0, isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_BINARY, '0, isa_pkg::OP_MUL);
    send_cmd(isa_pkg::KIND_DUP, '0, isa_pkg::OP_ADD);
    send_cmd(isa_pkg::KIND_DUP, '0, isa_pkg::OP_ADD);
  endtask

  task automatic test_random_stream();
    int unsigned done;
    int unsigned step;
    int unsigned target;
    int unsigned push_w;
    int          pick;
    done   = 0;
    step   = 0;
    target = 8;
    while (done < RANDOM_CMDS) begin
      if (step % 100 == 0) begin
        target  = $urandom_range(0, isa_pkg::STACK_DEPTH);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      if (step == RANDOM_CMDS / 2) wait_drain();
      step++;
      push_w = (held < target) ? 50 : 12;
      pick   = $urandom_range(0, 99);
      if (pick < 2) begin
        send_cmd(isa_pkg::KIND_W'($urandom_range(int'(isa_pkg::KIND_BINARY) + 1,
                                                 (1 << isa_pkg::KIND_W) - 1)),
                 $urandom(), isa_pkg::OP_W'($urandom()));
      end else begin
        done++;
        if (pick < 4) begin
          send_cmd(isa_pkg::KIND_BINARY, $urandom(),
                   isa_pkg::OP_W'($urandom_range(int'(isa_pkg::OP_SHR) + 1,
                                                 (1 << isa_pkg::OP_W) - 1)));
        end else if (pick < 5) begin
          send_cmd(isa_pkg::KIND_UNARY, $urandom(),
                   isa_pkg::OP_W'($urandom_range(int'(isa_pkg::UOP_NOT) + 1,
                                                 (1 << isa_pkg::OP_W) - 1)));
        end else if (pick < 5 + push_w) begin
          send_cmd(isa_pkg::KIND_PUSH, pick_word(), isa_pkg::OP_W'($urandom()));
        end else if (pick < 13 + push_w) begin
          send_cmd(isa_pkg::KIND_POP, $urandom(), isa_pkg::OP_W'($urandom()));
        end else if (pick < 21 + push_w) begin
          send_cmd(isa_pkg::KIND_DUP, $urandom(), isa_pkg::OP_W'($urandom()));
        end else if (pick < 33 + push_w) begin
          send_cmd(isa_pkg::KIND_UNARY, $urandom(),
                   isa_pkg::OP_W'($urandom_range(int'(isa_pkg::UOP_PLUS),
                                                 int'(isa_pkg::UOP_NOT))));
        end else begin
          send_cmd(isa_pkg::KIND_BINARY, $urandom(),
                   isa_pkg::OP_W'($urandom_range(int'(isa_pkg::OP_ADD),
                                                 int'(isa_pkg::OP_SHR))));
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < isa_pkg::STACK_DEPTH; i++) stack_words[i] = '0;
    held             = 0;
    fault_now        = isa_pkg::FAULT_NONE;
    no_gaps          = 1'b0;
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= isa_pkg::KIND_PUSH;
    in_ch.push_value <= '0;
    in_ch.op_code    <= isa_pkg::OP_ADD;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_push_pop();
    test_unary_ops();
    test_binary_ops();
    test_division_cases();
    test_overflow();
    test_random_stream();
    wait_drain();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
